### design/hcih4_pkg.sv
// Shared types, constants and helpers for the HCI H:4 packet reassembler.
`default_nettype none
package hcih4_pkg;

    // Buffer size default
    localparam int unsigned MAX_PACKET_BYTES_DEF = 512;

    // Field widths of the beat payloads
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TYPE_W = 3;
    localparam int unsigned OFF_W  = 9;
    localparam int unsigned LEN_W  = 10;
    localparam int unsigned HDR_W  = 3;
    localparam int unsigned PAY_W  = 16;

    // H:4 packet type codes
    localparam logic [BYTE_W-1:0] PKT_CMD = 8'h01;
    localparam logic [BYTE_W-1:0] PKT_ACL = 8'h02;
    localparam logic [BYTE_W-1:0] PKT_SCO = 8'h03;
    localparam logic [BYTE_W-1:0] PKT_EVT = 8'h04;

    // Fixed header sizes per type
    localparam logic [HDR_W-1:0] HDR_CMD = 3'd3;
    localparam logic [HDR_W-1:0] HDR_ACL = 3'd4;
    localparam logic [HDR_W-1:0] HDR_SCO = 3'd3;
    localparam logic [HDR_W-1:0] HDR_EVT = 3'd2;
    localparam logic [HDR_W-1:0] HDR_NONE = 3'd0;

    // Header byte countdown value at which the ACL length low byte arrives
    localparam logic [HDR_W-1:0] HDR_ACL_LEN_LO = 3'd2;

    // Parser phase
    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_HDR  = 2'd1,
        PH_PAY  = 2'd2
    } t_phase;

    // One result beat
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [TYPE_W-1:0] packet_type;
        logic [OFF_W-1:0]  byte_offset;
        logic              byte_kept;
        logic              last_of_packet;
        logic [LEN_W-1:0]  packet_length;
    } t_result;

    // Handshake control from the result stage back to the pipeline
    typedef struct packed {
        logic advance;  // result register can take a beat this cycle
    } t_out_ctl;

    // Header length for a type byte, zero for an unknown type
    function automatic logic [HDR_W-1:0] header_size(input logic [BYTE_W-1:0] t);
        logic [HDR_W-1:0] h;
        case (t)
            PKT_CMD: h = HDR_CMD;
            PKT_ACL: h = HDR_ACL;
            PKT_SCO: h = HDR_SCO;
            PKT_EVT: h = HDR_EVT;
            default: h = HDR_NONE;
        endcase
        return h;
    endfunction

endpackage
`default_nettype wire

### design/hcih4_in_stage.sv
// Input register stage: captures one stream byte per beat.
`default_nettype none
module hcih4_in_stage (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [hcih4_pkg::BYTE_W-1:0]  i_rx_byte,
    input  wire hcih4_pkg::t_out_ctl           i_ctl,
    output logic                               o_fire,
    output logic [hcih4_pkg::BYTE_W-1:0]       o_byte
);

    logic                         r_valid;
    logic                         n_valid;
    logic [hcih4_pkg::BYTE_W-1:0] r_byte;
    logic                         w_take;

    // Hold the beat while the result side is blocked
    assign o_stall = r_valid && !i_ctl.advance;
    assign w_take  = i_valid && !o_stall;
    assign o_fire  = r_valid && i_ctl.advance;
    assign o_byte  = r_byte;

    // Advance the valid flag
    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (o_fire) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture payload on accept
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_rx_byte;
        end
    end

endmodule
`default_nettype wire

### design/hcih4_parser.sv
// Packet parser: phase tracking, header and payload counters, beat tagging.
`default_nettype none
module hcih4_parser #(
    parameter int unsigned MAX_PACKET_BYTES = hcih4_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_fire,
    input  wire logic [hcih4_pkg::BYTE_W-1:0] i_byte,
    output logic                              o_res_valid,
    output hcih4_pkg::t_result                o_res
);

    localparam int unsigned WPOS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int unsigned XW     = (WPOS_W > hcih4_pkg::LEN_W) ? WPOS_W
                                                                 : hcih4_pkg::LEN_W;
    localparam logic [WPOS_W-1:0] WPOS_MAX = WPOS_W'(MAX_PACKET_BYTES);
    localparam logic [WPOS_W-1:0] WPOS_ONE = WPOS_W'(1);

    hcih4_pkg::t_phase               r_phase, n_phase;
    logic [hcih4_pkg::HDR_W-1:0]     r_hdr_left, n_hdr_left;
    logic [hcih4_pkg::PAY_W-1:0]     r_pay_left, n_pay_left;
    logic [WPOS_W-1:0]               r_wpos, n_wpos;
    logic [hcih4_pkg::TYPE_W-1:0]    r_type, n_type;
    logic [hcih4_pkg::BYTE_W-1:0]    r_len_lo, n_len_lo;

    logic [hcih4_pkg::HDR_W-1:0]     w_hsize;
    logic                            w_kept;
    logic [WPOS_W-1:0]               w_wpos_inc;
    logic [hcih4_pkg::PAY_W-1:0]     w_plen;
    logic                            w_hdr_end;
    logic                            w_pay_end;
    logic                            w_is_acl;
    logic                            w_last;
    logic [XW-1:0]                   w_off_x;
    logic [XW-1:0]                   w_len_x;

    // Decode shared terms
    assign w_hsize    = hcih4_pkg::header_size(i_byte);
    assign w_kept     = r_wpos < WPOS_MAX;
    assign w_wpos_inc = w_kept ? (r_wpos + WPOS_ONE) : r_wpos;
    assign w_is_acl   = r_type == hcih4_pkg::TYPE_W'(hcih4_pkg::PKT_ACL);
    assign w_plen     = w_is_acl ? {i_byte, r_len_lo}
                                 : {{(hcih4_pkg::PAY_W-hcih4_pkg::BYTE_W){1'b0}}, i_byte};
    assign w_hdr_end  = r_hdr_left <= hcih4_pkg::HDR_W'(1);
    assign w_pay_end  = r_pay_left <= hcih4_pkg::PAY_W'(1);
    assign w_off_x    = w_kept ? XW'(r_wpos) : '0;
    assign w_len_x    = XW'(w_wpos_inc);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            hcih4_pkg::PH_HDR: begin
                if (w_hdr_end) begin
                    n_phase = (w_plen == '0) ? hcih4_pkg::PH_TYPE : hcih4_pkg::PH_PAY;
                end
            end
            hcih4_pkg::PH_PAY: begin
                if (w_pay_end) begin
                    n_phase = hcih4_pkg::PH_TYPE;
                end
            end
            default: begin
                n_phase = (w_hsize == hcih4_pkg::HDR_NONE) ? hcih4_pkg::PH_TYPE
                                                           : hcih4_pkg::PH_HDR;
            end
        endcase
    end

    // Counters and result for this beat
    always_comb begin
        n_hdr_left  = r_hdr_left;
        n_pay_left  = r_pay_left;
        n_wpos      = r_wpos;
        n_type      = r_type;
        n_len_lo    = r_len_lo;
        w_last      = 1'b0;
        o_res_valid = 1'b1;
        o_res.data_byte      = i_byte;
        o_res.packet_type    = r_type;
        o_res.byte_offset    = w_off_x[hcih4_pkg::OFF_W-1:0];
        o_res.byte_kept      = w_kept;
        o_res.last_of_packet = 1'b0;
        o_res.packet_length  = '0;
        case (r_phase)
            hcih4_pkg::PH_HDR: begin
                n_wpos = w_wpos_inc;
                if (w_is_acl && (r_hdr_left == hcih4_pkg::HDR_ACL_LEN_LO)) begin
                    n_len_lo = i_byte;
                end
                if (w_hdr_end) begin
                    n_hdr_left = '0;
                    if (w_plen == '0) begin
                        w_last = 1'b1;
                    end else begin
                        n_pay_left = w_plen;
                    end
                end else begin
                    n_hdr_left = r_hdr_left - hcih4_pkg::HDR_W'(1);
                end
            end
            hcih4_pkg::PH_PAY: begin
                n_wpos = w_wpos_inc;
                if (w_pay_end) begin
                    n_pay_left = '0;
                    w_last     = 1'b1;
                end else begin
                    n_pay_left = r_pay_left - hcih4_pkg::PAY_W'(1);
                end
            end
            default: begin
                // Start a packet on a known type, drop anything else
                o_res_valid = w_hsize != hcih4_pkg::HDR_NONE;
                o_res.packet_type = i_byte[hcih4_pkg::TYPE_W-1:0];
                o_res.byte_offset = '0;
                o_res.byte_kept   = 1'b1;
                if (o_res_valid) begin
                    n_type     = i_byte[hcih4_pkg::TYPE_W-1:0];
                    n_hdr_left = w_hsize;
                    n_wpos     = WPOS_ONE;
                end
            end
        endcase
        o_res.last_of_packet = w_last;
        if (w_last) begin
            o_res.packet_length = w_len_x[hcih4_pkg::LEN_W-1:0];
        end
    end

    // Update state on each fired beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= hcih4_pkg::PH_TYPE;
            r_hdr_left <= '0;
            r_pay_left <= '0;
            r_wpos     <= '0;
            r_type     <= '0;
            r_len_lo   <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_hdr_left <= n_hdr_left;
            r_pay_left <= n_pay_left;
            r_wpos     <= n_wpos;
            r_type     <= n_type;
            r_len_lo   <= n_len_lo;
        end
    end

endmodule
`default_nettype wire

### design/hcih4_out_stage.sv
// Result register stage: holds one tagged beat until the consumer takes it.
`default_nettype none
module hcih4_out_stage (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire hcih4_pkg::t_result   i_res,
    input  wire logic                 i_stall,
    output logic                      o_valid,
    output hcih4_pkg::t_result        o_res,
    output hcih4_pkg::t_out_ctl       o_ctl
);

    logic               r_valid;
    logic               n_valid;
    hcih4_pkg::t_result r_res;

    assign o_valid       = r_valid;
    assign o_res         = r_res;
    assign o_ctl.advance = !r_valid || !i_stall;

    // Fill on load, empty once taken
    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

### design/hci_h4_packet_reassembler.sv
// Top level of the HCI H:4 packet reassembler.
//
//  Channel  | Valid    | Stall    | Payload
//  ---------+----------+----------+--------------------------------------------
//  input    | i_valid  | o_stall  | i_rx_byte
//  output   | o_valid  | i_stall  | o_data_byte, o_packet_type, o_byte_offset,
//           |          |          | o_byte_kept, o_last_of_packet, o_packet_length
//
// One byte per cycle sustained while the output is not stalled; an accepted beat
// is taken by the input register and then by the result register, which drives
// the result ports.
// Unknown type bytes are consumed and produce no beat.
// Reset is synchronous, active low, and returns the parser to type wait.
// A stall on the output holds the result and backs up through the input
// register; both registers keep a beat each meanwhile.
`default_nettype none
module hci_h4_packet_reassembler #(
    parameter int unsigned MAX_PACKET_BYTES = hcih4_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [hcih4_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [hcih4_pkg::BYTE_W-1:0]      o_data_byte,
    output logic [hcih4_pkg::TYPE_W-1:0]      o_packet_type,
    output logic [hcih4_pkg::OFF_W-1:0]       o_byte_offset,
    output logic                              o_byte_kept,
    output logic                              o_last_of_packet,
    output logic [hcih4_pkg::LEN_W-1:0]       o_packet_length
);

    hcih4_pkg::t_out_ctl          w_ctl;
    logic                         w_fire;
    logic [hcih4_pkg::BYTE_W-1:0] w_byte;
    logic                         w_res_valid;
    hcih4_pkg::t_result           w_res;
    hcih4_pkg::t_result           w_out;

    hcih4_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .i_ctl     (w_ctl),
        .o_fire    (w_fire),
        .o_byte    (w_byte)
    );

    hcih4_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_byte      (w_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    hcih4_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire && w_res_valid),
        .i_res   (w_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (w_out),
        .o_ctl   (w_ctl)
    );

    // Spread result fields onto ports
    assign o_data_byte      = w_out.data_byte;
    assign o_packet_type    = w_out.packet_type;
    assign o_byte_offset    = w_out.byte_offset;
    assign o_byte_kept      = w_out.byte_kept;
    assign o_last_of_packet = w_out.last_of_packet;
    assign o_packet_length  = w_out.packet_length;

endmodule
`default_nettype wire

### design/hcih4_checker.sv
// Port-level checker for the HCI H:4 packet reassembler, with its bind.
`default_nettype none
module hcih4_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_valid,
    input wire logic                         o_stall,
    input wire logic [hcih4_pkg::BYTE_W-1:0] i_rx_byte,
    input wire logic                         o_valid,
    input wire logic                         i_stall,
    input wire logic [hcih4_pkg::BYTE_W-1:0] o_data_byte,
    input wire logic [hcih4_pkg::TYPE_W-1:0] o_packet_type,
    input wire logic [hcih4_pkg::OFF_W-1:0]  o_byte_offset,
    input wire logic                         o_byte_kept,
    input wire logic                         o_last_of_packet,
    input wire logic [hcih4_pkg::LEN_W-1:0]  o_packet_length
);

    // Output empties on reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data_byte)
            && $stable(o_byte_offset) && $stable(o_packet_length))
        else $error("stalled result changed");

    // Truncated bytes carry no offset
    a_drop_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_kept |-> o_byte_offset == '0)
        else $error("offset on a dropped byte");

    // Length shows only with the last flag
    a_len_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_packet |-> o_packet_length == '0)
        else $error("length without last flag");

    // Only known packet types leave the block
    a_known_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            (o_packet_type == hcih4_pkg::TYPE_W'(hcih4_pkg::PKT_CMD))
            || (o_packet_type == hcih4_pkg::TYPE_W'(hcih4_pkg::PKT_ACL))
            || (o_packet_type == hcih4_pkg::TYPE_W'(hcih4_pkg::PKT_SCO))
            || (o_packet_type == hcih4_pkg::TYPE_W'(hcih4_pkg::PKT_EVT)))
        else $error("unknown packet type on output");

endmodule

bind hci_h4_packet_reassembler hcih4_checker u_chk (.*);
`default_nettype wire
